// ===== hdl/prcis_pkg.sv =====
`default_nettype none
package prcis_pkg;

  // Default table depths
  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 256;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int IDX_W    = 8;
  localparam int COORD_W  = 32;
  localparam int BUCKET_W = 9;
  localparam int ROWCNT_W = 5;
  localparam int COLCNT_W = 9;
  localparam int EXT_W    = COORD_W + 2;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_ROW = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_COL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ROW_SM   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ROW_LOC  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COL      = 3'd4;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_ROW_OFFSET  = 3'd0;
  localparam logic [2:0] REG_ROW_COUNT   = 3'd1;
  localparam logic [2:0] REG_COL_COUNT   = 3'd2;
  localparam logic [2:0] REG_ROW_TOP     = 3'd3;
  localparam logic [2:0] REG_ROW_BOTTOM  = 3'd4;
  localparam logic [2:0] REG_COL_LEFT    = 3'd5;
  localparam logic [2:0] REG_COL_RIGHT   = 3'd6;

  // Register reset values
  localparam logic [ROWCNT_W-1:0] ROW_COUNT_RST = 5'd16;
  localparam logic [COLCNT_W-1:0] COL_COUNT_RST = 9'd144;

  // Answer for a position outside the window
  localparam logic [BUCKET_W-1:0] NO_BUCKET = '1;

endpackage
`default_nettype wire

// ===== hdl/pad_row_column_interval_search.sv =====
// Loads write one edge into an edge table and give no result. A query is searched by P probes,
// P = binary-search probes, one per cycle through the edge memory's read port: none
// outside the window, else at most ceil(log2(count + 1)) for rows, ceil(log2(count)) for cols.
// The result is registered with the last probe (at acceptance if there is none); no next item
// is taken until the result has reached the output register. Synchronous active-low reset
// sets control and configuration registers to their reset values; edge tables are not cleared.
`default_nettype none
module pad_row_column_interval_search #(
  parameter int MAX_ROWS = prcis_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = prcis_pkg::MAX_COLS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // input channel
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [prcis_pkg::CMD_W-1:0]           in_cmd,
  input  wire  [prcis_pkg::IDX_W-1:0]           in_entry_index,
  input  wire  signed [prcis_pkg::COORD_W-1:0]  in_edge_value,
  input  wire  signed [prcis_pkg::COORD_W-1:0]  in_position,
  // result channel
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [prcis_pkg::BUCKET_W-1:0] out_bucket_index,
  // configuration port
  input  wire                                   cfg_psel,
  input  wire                                   cfg_penable,
  input  wire                                   cfg_pwrite,
  input  wire  [prcis_pkg::CFG_AW-1:0]          cfg_paddr,
  input  wire  [prcis_pkg::CFG_DW-1:0]          cfg_pwdata,
  output logic [prcis_pkg::CFG_DW-1:0]          cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int RAW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RIW  = $clog2(MAX_ROWS + 2);
  localparam int CIW  = $clog2(MAX_COLS + 1);
  localparam int IW   = (RIW > CIW) ? RIW : CIW;
  localparam int CW   = prcis_pkg::COORD_W;
  localparam int XW   = prcis_pkg::EXT_W;
  localparam int BW   = prcis_pkg::BUCKET_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_RESULT} state_t;

  // Configuration registers
  logic signed [CW-1:0]                   row_offset_r;
  logic [prcis_pkg::ROWCNT_W-1:0]         row_count_r;
  logic [prcis_pkg::COLCNT_W-1:0]         col_count_r;
  logic signed [CW-1:0]                   row_top_r;
  logic signed [CW-1:0]                   row_bottom_r;
  logic signed [CW-1:0]                   col_left_r;
  logic signed [CW-1:0]                   col_right_r;

  // Search state
  state_t               state_r, state_nxt;
  logic [IW-1:0]        lo_r, lo_nxt;
  logic [IW-1:0]        hi_r, hi_nxt;
  logic [IW-1:0]        mid_r, mid_nxt;
  logic                 is_row_r, is_row_nxt;
  logic signed [CW-1:0] pos_r, pos_nxt;
  logic signed [CW-1:0] off_r, off_nxt;
  logic [BW-1:0]        res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BW-1:0]        out_bucket_r, out_bucket_nxt;

  // Edge memories
  logic signed [CW-1:0] row_mem [MAX_ROWS];
  logic signed [CW-1:0] col_mem [MAX_COLS];
  logic signed [CW-1:0] row_rdata_r;
  logic signed [CW-1:0] col_rdata_r;
  logic                 row_we, col_we;
  logic [RAW-1:0]       row_raddr;
  logic [CAW-1:0]       col_raddr;

  // Configuration write / read
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_offset_r <= '0;
      row_count_r  <= prcis_pkg::ROW_COUNT_RST;
      col_count_r  <= prcis_pkg::COL_COUNT_RST;
      row_top_r    <= '0;
      row_bottom_r <= '0;
      col_left_r   <= '0;
      col_right_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        prcis_pkg::REG_ROW_OFFSET: row_offset_r <= cfg_pwdata;
        prcis_pkg::REG_ROW_COUNT:  row_count_r  <= cfg_pwdata[prcis_pkg::ROWCNT_W-1:0];
        prcis_pkg::REG_COL_COUNT:  col_count_r  <= cfg_pwdata[prcis_pkg::COLCNT_W-1:0];
        prcis_pkg::REG_ROW_TOP:    row_top_r    <= cfg_pwdata;
        prcis_pkg::REG_ROW_BOTTOM: row_bottom_r <= cfg_pwdata;
        prcis_pkg::REG_COL_LEFT:   col_left_r   <= cfg_pwdata;
        prcis_pkg::REG_COL_RIGHT:  col_right_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      prcis_pkg::REG_ROW_OFFSET: cfg_prdata = row_offset_r;
      prcis_pkg::REG_ROW_COUNT:  cfg_prdata = CW'(row_count_r);
      prcis_pkg::REG_COL_COUNT:  cfg_prdata = CW'(col_count_r);
      prcis_pkg::REG_ROW_TOP:    cfg_prdata = row_top_r;
      prcis_pkg::REG_ROW_BOTTOM: cfg_prdata = row_bottom_r;
      prcis_pkg::REG_COL_LEFT:   cfg_prdata = col_left_r;
      prcis_pkg::REG_COL_RIGHT:  cfg_prdata = col_right_r;
      default:                   cfg_prdata = '0;
    endcase
  end

  // Query setup: counts clamped to table depth, window check on exact sums
  logic                 qry_row;
  logic signed [CW-1:0] qry_off;
  logic [IW-1:0]        row_n, col_n, start_hi;
  logic signed [XW-1:0] pos_x, win_hi_x, win_lo_x;
  logic                 in_window;

  always_comb begin
    qry_row  = (in_cmd == prcis_pkg::CMD_ROW_SM) || (in_cmd == prcis_pkg::CMD_ROW_LOC);
    qry_off  = (in_cmd == prcis_pkg::CMD_ROW_SM) ? row_offset_r : '0;
    row_n    = (int'(row_count_r) > MAX_ROWS) ? IW'(MAX_ROWS) : IW'(row_count_r);
    col_n    = (int'(col_count_r) > MAX_COLS) ? IW'(MAX_COLS) : IW'(col_count_r);
    start_hi = qry_row ? (row_n + IW'(1)) : col_n;
    pos_x    = XW'(in_position);
    if (qry_row) begin
      win_hi_x = XW'(row_top_r) + XW'(qry_off);
      win_lo_x = XW'(row_bottom_r) + XW'(qry_off);
    end else begin
      win_hi_x = XW'(col_right_r);
      win_lo_x = XW'(col_left_r);
    end
    in_window = !((pos_x > win_hi_x) || (pos_x < win_lo_x));
  end

  // One probe step: compare the edge just read against the position
  logic signed [CW-1:0] probe_edge;
  logic                 probe_gt, take_lo;
  logic [IW-1:0]        step_lo, step_hi;

  always_comb begin
    probe_edge = is_row_r ? row_rdata_r : col_rdata_r;
    probe_gt   = XW'(pos_r) > (XW'(probe_edge) + XW'(off_r));
    take_lo    = is_row_r ? !probe_gt : probe_gt;
    step_lo    = take_lo ? mid_r : lo_r;
    step_hi    = take_lo ? hi_r : mid_r;
  end

  // Interval candidate for this cycle, next midpoint and answer
  logic [IW-1:0]   cand_lo, cand_hi, cand_mid, mid_m1;
  logic            cand_row, cand_more;
  logic [BW-1:0]   cand_res;
  logic            out_free, in_acc;

  always_comb begin
    if (state_r == ST_SEARCH) begin
      cand_lo  = step_lo;
      cand_hi  = step_hi;
      cand_row = is_row_r;
    end else begin
      cand_lo  = '0;
      cand_hi  = start_hi;
      cand_row = qry_row;
    end
    cand_mid  = IW'(({1'b0, cand_hi} + {1'b0, cand_lo}) >> 1);
    cand_more = (cand_hi - cand_lo) > IW'(1);
    cand_res  = cand_row ? (BW'(cand_lo) - BW'(1)) : BW'(cand_lo);
    mid_m1    = cand_mid - IW'(1);
    row_raddr = mid_m1[RAW-1:0];
    col_raddr = cand_mid[CAW-1:0];
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    is_row_nxt     = is_row_r;
    pos_nxt        = pos_r;
    off_nxt        = off_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_bucket_nxt = out_bucket_r;
    row_we         = 1'b0;
    col_we         = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            prcis_pkg::CMD_LOAD_ROW: begin
              row_we = int'(in_entry_index) < MAX_ROWS;
            end
            prcis_pkg::CMD_LOAD_COL: begin
              col_we = int'(in_entry_index) < MAX_COLS;
            end
            prcis_pkg::CMD_ROW_SM, prcis_pkg::CMD_ROW_LOC, prcis_pkg::CMD_COL: begin
              is_row_nxt = qry_row;
              pos_nxt    = in_position;
              off_nxt    = qry_off;
              lo_nxt     = cand_lo;
              hi_nxt     = cand_hi;
              mid_nxt    = cand_mid;
              if (in_window && cand_more) begin
                state_nxt = ST_SEARCH;
              end else begin
                res_nxt = in_window ? cand_res : prcis_pkg::NO_BUCKET;
                if (out_free) begin
                  out_valid_nxt  = 1'b1;
                  out_bucket_nxt = res_nxt;
                end else begin
                  state_nxt = ST_RESULT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        lo_nxt  = cand_lo;
        hi_nxt  = cand_hi;
        mid_nxt = cand_mid;
        if (!cand_more) begin
          res_nxt = cand_res;
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_bucket_nxt = cand_res;
            state_nxt      = ST_IDLE;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_bucket_nxt = res_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    is_row_r     <= is_row_nxt;
    pos_r        <= pos_nxt;
    off_r        <= off_nxt;
    res_r        <= res_nxt;
    out_bucket_r <= out_bucket_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_bucket_index = out_bucket_r;

  // Row edge memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[RAW'(in_entry_index)] <= in_edge_value;
    end
    row_rdata_r <= row_mem[row_raddr];
  end

  // Column edge memory
  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[CAW'(in_entry_index)] <= in_edge_value;
    end
    col_rdata_r <= col_mem[col_raddr];
  end

endmodule
`default_nettype wire
